@@ src/fbpa_pkg.sv @@
// shared types and constants of the fixed block pool allocator
package fbpa_pkg;

  localparam int MAX_PAGES          = 64;
  localparam int MAX_BLOCKS         = 4096;
  localparam int BLOCK_HEADER_BYTES = 8;
  localparam int PAGE_HEADER_BYTES  = 8;

  localparam int HANDLE_W = 12;
  localparam int LINK_W   = 13;
  localparam int COUNT_W  = 13;
  localparam int PAGES_W  = 7;
  localparam int DIV_W    = 17;
  localparam int CFG_W    = 17;
  localparam int EPOCH_W  = 8;

  localparam logic [LINK_W-1:0]  LINK_NONE = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  // action codes
  localparam logic [1:0] ACT_ALLOC    = 2'd0;
  localparam logic [1:0] ACT_FREE     = 2'd1;
  localparam logic [1:0] ACT_FREE_ALL = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_DATA_BYTES = 2'd0;
  localparam logic [1:0] CFG_PAGE_BYTES = 2'd1;
  localparam logic [1:0] CFG_ALIGN_LOG2 = 2'd2;

  typedef struct packed {
    logic [1:0]          action;
    logic [HANDLE_W-1:0] block_handle;
  } fbpa_in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] granted_handle;
    logic [5:0]          page_number;
    logic [15:0]         byte_offset;
    logic                out_of_memory;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  total_blocks;
    logic [PAGES_W-1:0]  open_pages;
  } fbpa_out_t;

  // one free-list link, stamped with the pool epoch it was written in
  typedef struct packed {
    logic [EPOCH_W-1:0] stamp;
    logic [LINK_W-1:0]  link;
  } link_entry_t;

  typedef struct packed {
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ src/fbpa_div.sv @@
// restoring divider, one quotient bit per cycle
module fbpa_div
  import fbpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  div_req_t         req,
  output div_stat_t        stat,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DIV_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, quo[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (fits) begin
          rem <= DIV_W'(shifted - {1'b0, dvs});
        end else begin
          rem <= shifted[DIV_W-1:0];
        end
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat      = '{busy: busy, done: done};
  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ src/fixed_block_pool_allocator.sv @@
// Fixed-size block pool allocator. Free blocks form a LIFO list held in a 4096-entry link
// memory with a registered read. A free or a free-all passes through the execute and done
// states to its result; an allocate also reads the link memory and then waits for the
// serial divider that splits the granted handle into page and slot, followed by the offset
// multiply. A new page costs one memory write: its blocks follow each other implicitly and
// only the last slot is written, so links are stamped with a pool epoch and stale ones are
// ignored. After reset, and after every 255th emptying of the pool (free-all or register
// write), a clearing pass runs through all 4096 link-memory entries and no item is taken. A
// register write also recomputes the block stride and blocks per page, and no item is taken
// meanwhile. The input side is free again as soon as a result sits in the output register.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  fbpa_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output fbpa_out_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(MAX_BLOCKS);

  typedef enum logic [2:0] {
    S_IDLE, S_GEO_WAIT, S_EXEC, S_RD, S_LINK, S_DIV_WAIT, S_FIN, S_DONE
  } state_t;

  state_t state;

  // configuration and geometry
  logic [12:0]      data_bytes;
  logic [16:0]      page_bytes;
  logic [3:0]       align_log2;
  logic             geo_req;
  logic [DIV_W-1:0] block_stride;
  logic [DIV_W-1:0] slots_per_page;

  // pool state
  logic [LINK_W-1:0]   list_head;
  logic [PAGES_W-1:0]  page_count;
  logic [COUNT_W-1:0]  block_count;
  logic [COUNT_W-1:0]  free_blocks;
  logic [EPOCH_W-1:0]  epoch;
  logic                sweeping;
  logic [ADDR_W-1:0]   sweep_cnt;

  // item in flight
  fbpa_in_t            cur;
  logic [HANDLE_W-1:0] res_granted;
  logic [5:0]          res_page;
  logic [15:0]         res_offset;
  logic                res_oom;
  logic [15:0]         prod_lo;

  // link memory
  link_entry_t         mem [MAX_BLOCKS];
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  link_entry_t         mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  link_entry_t         mem_rdata;

  // divider
  logic                div_start;
  div_req_t            div_req;
  div_stat_t           div_stat;
  logic [DIV_W-1:0]    div_quo;
  logic [DIV_W-1:0]    div_rem;

  logic [12:0]         need_bytes;
  logic [DIV_W-1:0]    align_mask;
  logic [DIV_W-1:0]    stride_calc;
  logic                geo_go;
  logic                geo_div;
  logic                in_accept;
  logic                list_empty;
  logic                open_fail;
  logic                push_ok;
  logic [DIV_W-1:0]    last_slot;
  logic [LINK_W-1:0]   next_head;
  logic [28:0]         prod;
  logic                out_free;

  assign need_bytes  = (data_bytes > 13'(BLOCK_HEADER_BYTES)) ? data_bytes
                                                              : 13'(BLOCK_HEADER_BYTES);
  assign align_mask  = (DIV_W'(1) << align_log2) - DIV_W'(1);
  assign stride_calc = (DIV_W'(need_bytes) + align_mask) & ~align_mask;

  assign geo_go    = (state == S_IDLE) && !sweeping && geo_req;
  assign geo_div   = page_bytes > 17'(PAGE_HEADER_BYTES);
  assign in_stall  = !((state == S_IDLE) && !sweeping && !geo_req);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign list_empty = (list_head == LINK_NONE);
  assign open_fail  = (page_count >= PAGES_W'(MAX_PAGES)) || (slots_per_page == '0) ||
                      (slots_per_page > (DIV_W'(MAX_BLOCKS) - DIV_W'(block_count)));
  assign push_ok    = ({1'b0, cur.block_handle} < block_count) && (free_blocks < block_count);
  assign last_slot  = DIV_W'(block_count) + slots_per_page - DIV_W'(1);

  // a link stamped in an older epoch belongs to an emptied pool: the block then
  // still follows its page neighbour
  assign next_head = (mem_rdata.stamp == epoch) ? mem_rdata.link : list_head + 1'b1;

  assign prod = div_rem[11:0] * block_stride;

  always_comb begin
    div_start = 1'b0;
    div_req   = '{dividend: '0, divisor: slots_per_page};
    if (geo_go && geo_div) begin
      div_start = 1'b1;
      div_req   = '{dividend: page_bytes - 17'(PAGE_HEADER_BYTES), divisor: stride_calc};
    end else if (state == S_LINK) begin
      div_start = 1'b1;
      div_req   = '{dividend: DIV_W'(list_head), divisor: slots_per_page};
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '{stamp: '0, link: LINK_NONE};
    if (sweeping) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_cnt;
    end else if (state == S_EXEC && cur.action == ACT_ALLOC && list_empty && !open_fail) begin
      mem_we    = 1'b1;
      mem_waddr = last_slot[ADDR_W-1:0];
      mem_wdata = '{stamp: epoch, link: LINK_NONE};
    end else if (state == S_EXEC && cur.action == ACT_FREE && push_ok) begin
      mem_we    = 1'b1;
      mem_waddr = cur.block_handle;
      mem_wdata = '{stamp: epoch, link: list_head};
    end
  end

  assign mem_re    = (state == S_RD);
  assign mem_raddr = list_head[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  fbpa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .req       (div_req),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      data_bytes     <= 13'd8;
      page_bytes     <= 17'd8192;
      align_log2     <= 4'd3;
      geo_req        <= 1'b1;
      block_stride   <= '0;
      slots_per_page <= '0;
      list_head      <= LINK_NONE;
      page_count     <= '0;
      block_count    <= '0;
      free_blocks    <= '0;
      epoch          <= EPOCH_W'(1);
      sweeping       <= 1'b1;
      sweep_cnt      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (sweeping) begin
        sweep_cnt <= sweep_cnt + 1'b1;
        if (sweep_cnt == '1) begin
          sweeping <= 1'b0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (geo_go) begin
            geo_req      <= 1'b0;
            block_stride <= stride_calc;
            if (geo_div) begin
              state <= S_GEO_WAIT;
            end else begin
              slots_per_page <= '0;
            end
          end else if (in_accept) begin
            cur   <= in_data;
            state <= S_EXEC;
          end
        end
        S_GEO_WAIT: begin
          if (div_stat.done) begin
            slots_per_page <= div_quo;
            state          <= S_IDLE;
          end
        end
        S_EXEC: begin
          res_granted <= '0;
          res_page    <= '0;
          res_offset  <= '0;
          res_oom     <= 1'b0;
          state       <= S_DONE;
          case (cur.action)
            ACT_ALLOC: begin
              if (!list_empty) begin
                state <= S_RD;
              end else if (open_fail) begin
                res_oom <= 1'b1;
              end else begin
                list_head   <= LINK_W'(block_count);
                page_count  <= page_count + 1'b1;
                block_count <= block_count + COUNT_W'(slots_per_page);
                free_blocks <= free_blocks + COUNT_W'(slots_per_page);
                state       <= S_RD;
              end
            end
            ACT_FREE: begin
              if (push_ok) begin
                list_head   <= LINK_W'(cur.block_handle);
                free_blocks <= free_blocks + 1'b1;
              end
            end
            ACT_FREE_ALL: begin
              list_head   <= LINK_NONE;
              page_count  <= '0;
              block_count <= '0;
              free_blocks <= '0;
              if (epoch == EPOCH_MAX) begin
                epoch     <= EPOCH_W'(1);
                sweeping  <= 1'b1;
                sweep_cnt <= '0;
              end else begin
                epoch <= epoch + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        S_RD: begin
          state <= S_LINK;
        end
        S_LINK: begin
          res_granted <= list_head[HANDLE_W-1:0];
          list_head   <= next_head;
          if (free_blocks != '0) begin
            free_blocks <= free_blocks - 1'b1;
          end
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_stat.done) begin
            res_page <= div_quo[5:0];
            prod_lo  <= prod[15:0];
            state    <= S_FIN;
          end
        end
        S_FIN: begin
          res_offset <= prod_lo + 16'(PAGE_HEADER_BYTES);
          state      <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_data <= '{granted_handle: res_granted,
                          page_number:    res_page,
                          byte_offset:    res_offset,
                          out_of_memory:  res_oom,
                          free_count:     free_blocks,
                          total_blocks:   block_count,
                          open_pages:     page_count};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // register writes must come only while idle (not enforced); indexes 0-2 empty the pool
      if (cfg_we) begin
        case (cfg_index)
          CFG_DATA_BYTES: data_bytes <= cfg_data[12:0];
          CFG_PAGE_BYTES: page_bytes <= cfg_data[16:0];
          CFG_ALIGN_LOG2: align_log2 <= cfg_data[3:0];
          default: begin
          end
        endcase
        if (cfg_index == CFG_DATA_BYTES || cfg_index == CFG_PAGE_BYTES ||
            cfg_index == CFG_ALIGN_LOG2) begin
          geo_req     <= 1'b1;
          list_head   <= LINK_NONE;
          page_count  <= '0;
          block_count <= '0;
          free_blocks <= '0;
          if (epoch == EPOCH_MAX) begin
            epoch     <= EPOCH_W'(1);
            sweeping  <= 1'b1;
            sweep_cnt <= '0;
          end else begin
            epoch <= epoch + 1'b1;
          end
        end
      end
    end
  end

  a_free_le_total: assert property (@(posedge clk) disable iff (rst)
    free_blocks <= block_count)
    else $error("free block count exceeds opened blocks");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("link memory read and written in one cycle");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("epoch reached the cleared stamp value");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result transfer raised outside the done state");

endmodule
